[rtl/gwm_pkg.sv]
// Shared types and constants for the glob wildcard matcher.
package gwm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } gwm_state_t;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_END     = 2'd3
  } gwm_cmd_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ANY   = 8'h3F;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // Control from the sequencer to the position walker.
  typedef struct packed {
    logic start;       // begin a walk, clears the new set (seeds position 0 on a restart)
    logic advance;     // walk consumes a subject byte (else restart only)
    logic byte_valid;  // pattern byte on pbyte is valid
    logic flush;       // end of pattern, close an open class
  } walk_ctl_t;

endpackage

[rtl/gwm_walk.sv]
// Position walker: parses pattern bytes in order and builds the next active set.
module gwm_walk
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  walk_ctl_t                            ctl,
  input  logic [7:0]                           pbyte,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]     q,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]     len,
  input  logic [7:0]                           sym,
  input  logic [PATTERN_MAX:0]                 active,
  output logic [PATTERN_MAX:0]                 fresh_next
);

  localparam int PW = $clog2(PATTERN_MAX + 1);

  logic              mode_adv;
  logic              in_class, in_class_next;
  logic              neg_ok, neg_ok_next;
  logic              negate, negate_next;
  logic              hit, hit_next;
  logic              have_last, have_last_next;
  logic              dash_pend, dash_pend_next;
  logic [7:0]        last, last_next;
  logic [PW-1:0]     elem_p, elem_p_next;
  logic [PATTERN_MAX:0] fresh;

  logic              fin;
  logic              fin_star;
  logic              fin_ok;
  logic [PW-1:0]     fin_p;
  logic [PW-1:0]     fin_nx;

  // Element parser: one pattern byte a cycle.
  always_comb begin
    in_class_next  = in_class;
    neg_ok_next    = neg_ok;
    negate_next    = negate;
    hit_next       = hit;
    have_last_next = have_last;
    dash_pend_next = dash_pend;
    last_next      = last;
    elem_p_next    = elem_p;
    fin            = 1'b0;
    fin_star       = 1'b0;
    fin_ok         = 1'b0;
    fin_p          = elem_p;
    fin_nx         = q + PW'(1);
    if (ctl.start) begin
      in_class_next = 1'b0;
    end else if (ctl.byte_valid) begin
      if (!in_class) begin
        if (pbyte == CH_OPEN) begin
          in_class_next  = 1'b1;
          neg_ok_next    = 1'b1;
          negate_next    = 1'b0;
          hit_next       = 1'b0;
          have_last_next = 1'b0;
          dash_pend_next = 1'b0;
          elem_p_next    = q;
        end else begin
          fin      = 1'b1;
          fin_p    = q;
          fin_star = (pbyte == CH_STAR);
          fin_ok   = (pbyte == CH_STAR) || (pbyte == CH_ANY) || (pbyte == sym);
        end
      end else begin
        neg_ok_next = 1'b0;
        if (neg_ok && (pbyte == CH_BANG || pbyte == CH_CARET)) begin
          negate_next = 1'b1;
        end else if (dash_pend) begin
          // dash held back until we see whether a range end follows
          if (pbyte == CH_CLOSE) begin
            fin           = 1'b1;
            fin_ok        = negate ^ (hit | (sym == CH_DASH));
            in_class_next = 1'b0;
          end else begin
            hit_next       = hit | ((sym >= last) && (sym <= pbyte));
            have_last_next = 1'b0;
            dash_pend_next = 1'b0;
          end
        end else if (pbyte == CH_CLOSE) begin
          fin           = 1'b1;
          fin_ok        = negate ^ hit;
          in_class_next = 1'b0;
        end else if (pbyte == CH_DASH && have_last) begin
          dash_pend_next = 1'b1;
        end else begin
          last_next      = pbyte;
          have_last_next = 1'b1;
          hit_next       = hit | (sym == pbyte);
        end
      end
    end else if (ctl.flush && in_class) begin
      // unclosed class runs to the end of the pattern
      fin           = 1'b1;
      fin_nx        = len;
      fin_ok        = negate ^ (hit | (dash_pend && sym == CH_DASH));
      in_class_next = 1'b0;
    end
  end

  // New set update with star closure folded in; targets lie at or ahead of the element.
  always_comb begin
    fresh_next = fresh;
    if (fin) begin
      if (fin_star) begin
        if (mode_adv && active[fin_p]) fresh_next[fin_p] = 1'b1;
        if (fresh_next[fin_p]) fresh_next[fin_nx] = 1'b1;
      end else if (mode_adv && active[fin_p] && fin_ok) begin
        fresh_next[fin_nx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_class <= 1'b0;
      mode_adv <= 1'b0;
      fresh    <= '0;
    end else begin
      in_class <= in_class_next;
      if (ctl.start) begin
        mode_adv <= ctl.advance;
        fresh    <= ctl.advance ? '0 : (PATTERN_MAX+1)'(1);
      end else begin
        fresh <= fresh_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_ok    <= neg_ok_next;
    negate    <= negate_next;
    hit       <= hit_next;
    have_last <= have_last_next;
    dash_pend <= dash_pend_next;
    last      <= last_next;
    elem_p    <= elem_p_next;
  end

endmodule

[rtl/glob_wildcard_matcher.sv]
// Glob wildcard matcher top level: pattern store, walk sequencer and result register.
//
// Every input word (clear, append, subject byte, end of subject) starts one walk
// over the stored pattern: the pattern memory is read one byte a cycle and each
// element updates the set of active positions; the walk covers the pattern that
// the word leaves behind, and s_tready is low throughout. The end-of-subject result
// sits in an output register; input stays closed while a result waits and opens in
// the cycle it is taken.
module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int PW = $clog2(PATTERN_MAX + 1);
  localparam int AW = $clog2(PATTERN_MAX);

  gwm_state_t state, state_next;

  logic [7:0]           pattern_mem [PATTERN_MAX];
  logic [7:0]           rdata;
  logic [PW-1:0]        len;
  logic                 ovf;
  logic [PATTERN_MAX:0] active;
  logic [PATTERN_MAX:0] fresh_next;
  logic [7:0]           sym;
  logic [PW-1:0]        rd_idx;
  logic [PW-1:0]        q;
  logic                 dv;
  logic                 rd_en;
  logic                 accept;
  logic                 out_matched;
  logic                 out_ovf;
  gwm_cmd_t             cmd;
  walk_ctl_t            ctl;

  assign cmd    = gwm_cmd_t'(s_tuser);
  assign accept = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_WALK;
      ST_WALK:  if (!dv && rd_idx >= len) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = (state == ST_IDLE) && (!m_tvalid || m_tready);
    rd_en          = (state == ST_WALK) && (rd_idx < len);
    ctl.start      = accept;
    ctl.advance    = (cmd == CMD_SUBJECT);
    ctl.byte_valid = (state == ST_WALK) && dv;
    ctl.flush      = (state == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      ovf      <= 1'b0;
      active   <= (PATTERN_MAX+1)'(1);
      rd_idx   <= '0;
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= rd_en;
      if (rd_en) rd_idx <= rd_idx + PW'(1);
      if (m_tvalid && m_tready && !(accept && cmd == CMD_END)) m_tvalid <= 1'b0;
      if (accept) begin
        rd_idx <= '0;
        unique case (cmd)
          CMD_CLEAR: begin
            len <= '0;
            ovf <= 1'b0;
          end
          CMD_APPEND: begin
            if (len < PW'(PATTERN_MAX)) len <= len + PW'(1);
            else ovf <= 1'b1;
          end
          CMD_SUBJECT: ;
          CMD_END:     m_tvalid <= 1'b1;
          default: ;
        endcase
      end
      if (state == ST_FLUSH) active <= fresh_next;
    end
  end

  // pattern store and its registered read port
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_APPEND && len < PW'(PATTERN_MAX)) begin
      pattern_mem[len[AW-1:0]] <= s_tdata;
    end
    if (rd_en) rdata <= pattern_mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    q <= rd_idx;
    if (accept && cmd == CMD_SUBJECT) sym <= s_tdata;
    if (accept && cmd == CMD_END) begin
      out_matched <= active[len];
      out_ovf     <= ovf;
    end
  end

  assign m_tdata = {6'b0, out_ovf, out_matched};

  gwm_walk #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .pbyte      (rdata),
    .q          (q),
    .len        (len),
    .sym        (sym),
    .active     (active),
    .fresh_next (fresh_next)
  );

endmodule

[rtl/gwm_checker.sv]
// Port-level checker for the glob wildcard matcher, bound to the top level.
module gwm_checker
  import gwm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // end of subject always yields a result next cycle
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_END |=> m_tvalid)
    else $error("end of subject gave no result");

  // other commands never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != CMD_END && !m_tvalid |=> !m_tvalid)
    else $error("result without end of subject");

  // each word starts a walk, so input is closed right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during a walk");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[sim/glob_wildcard_matcher_test.sv]
// Self-checking testbench for the glob wildcard matcher: directed globs, then random words.
module glob_wildcard_matcher_test;
  import gwm_pkg::*;

  localparam int PAT_DEPTH = 32;
  localparam int WORD_TARGET = 675;          // directed words plus about 650 random ones
  localparam int DRAIN_CYCLES = PAT_DEPTH + 8;

  // Predicts end-of-subject verdicts and checks the result words against them.
  class glob_scoreboard;
    typedef struct packed {
      logic matched;
      logic overflow;
    } verdict_t;

    logic [7:0] pat [PAT_DEPTH];
    int plen;
    logic [PAT_DEPTH:0] live;
    logic ovf;
    verdict_t pending [$];
    int errors;

    function new();
      plen = 0;
      ovf = 1'b0;
      errors = 0;
      live = '0;
      restart_subject();
    endfunction

    // Does the element at p accept byte c; nx is where the next element starts.
    function bit element_fits(int p, logic [7:0] c, output int nx, output bit star);
      int q;
      bit neg, hit, have_lo;
      logic [7:0] lo;
      star = 1'b0;
      nx = p + 1;
      case (pat[p])
        CH_STAR: begin
          star = 1'b1;
          return 1'b1;
        end
        CH_ANY: return 1'b1;
        CH_OPEN: begin
          q = p + 1;
          neg = 1'b0;
          hit = 1'b0;
          have_lo = 1'b0;
          lo = '0;
          if (q < plen && (pat[q] == CH_BANG || pat[q] == CH_CARET)) begin
            neg = 1'b1;
            q++;
          end
          while (q < plen && pat[q] != CH_CLOSE) begin
            // a range needs a prior single member and a bound that is not the close
            if (pat[q] == CH_DASH && have_lo && q + 1 < plen && pat[q + 1] != CH_CLOSE) begin
              if (c >= lo && c <= pat[q + 1]) hit = 1'b1;
              have_lo = 1'b0;
              q += 2;
            end else begin
              lo = pat[q];
              have_lo = 1'b1;
              if (c == lo) hit = 1'b1;
              q++;
            end
          end
          if (q < plen) q++;  // unclosed class runs to the end
          nx = q;
          return neg ? !hit : hit;
        end
        default: return pat[p] == c;
      endcase
    endfunction

    function void close_stars();
      int p, nx;
      bit star;
      p = 0;
      while (p < plen) begin
        void'(element_fits(p, 8'h00, nx, star));
        if (star && live[p]) live[nx] = 1'b1;
        p = nx;
      end
    endfunction

    function void restart_subject();
      live = '0;
      live[0] = 1'b1;
      close_stars();
    endfunction

    function void consume_byte(logic [7:0] c);
      logic [PAT_DEPTH:0] fresh;
      int p, nx;
      bit star, ok;
      fresh = '0;
      p = 0;
      while (p < plen) begin
        ok = element_fits(p, c, nx, star);
        if (live[p]) begin
          if (star) fresh[p] = 1'b1;
          else if (ok) fresh[nx] = 1'b1;
        end
        p = nx;
      end
      live = fresh;
      close_stars();
    endfunction

    function void note_word(gwm_cmd_t cmd, logic [7:0] sym);
      verdict_t v;
      case (cmd)
        CMD_CLEAR: begin
          plen = 0;
          ovf = 1'b0;
          restart_subject();
        end
        CMD_APPEND: begin
          if (plen < PAT_DEPTH) begin
            pat[plen] = sym;
            plen++;
          end else begin
            ovf = 1'b1;
          end
          restart_subject();
        end
        CMD_SUBJECT: consume_byte(sym);
        default: begin
          v.matched = live[plen];
          v.overflow = ovf;
          pending.push_back(v);
          restart_subject();
        end
      endcase
    endfunction

    function void check_word(logic [7:0] tdata);
      verdict_t v;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", tdata);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (tdata[0] !== v.matched) begin
        $error("matched: expected %0d, got %0d", v.matched, tdata[0]);
        errors++;
      end
      if (tdata[1] !== v.overflow) begin
        $error("pattern_overflow: expected %0d, got %0d", v.overflow, tdata[1]);
        errors++;
      end
      if (tdata[7:2] !== 6'd0) begin
        $error("padding: expected %0d, got %0d", 0, tdata[7:2]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;

  glob_scoreboard sb = new();
  int words_sent = 0;
  bit no_gaps = 1'b0;

  glob_wildcard_matcher #(.PATTERN_MAX(PAT_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes that exercise the glob syntax, plus plain letters.
  localparam logic [7:0] GLOB_SET [10] = '{
    "a", "b", "c", CH_STAR, CH_ANY, CH_OPEN, CH_CLOSE, CH_BANG, CH_CARET, CH_DASH
  };
  localparam logic [7:0] TEXT_SET [5] = '{"a", "b", "c", CH_DASH, CH_CLOSE};

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(99) < 80) return TEXT_SET[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_word(gwm_cmd_t cmd, logic [7:0] sym);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= sym;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(cmd, sym);
    words_sent++;
  endtask

  task automatic load_glob(string g);
    send_word(CMD_CLEAR, 8'h00);
    for (int i = 0; i < g.len(); i++) send_word(CMD_APPEND, g[i]);
  endtask

  task automatic try_subject(string s);
    for (int i = 0; i < s.len(); i++) send_word(CMD_SUBJECT, s[i]);
    send_word(CMD_END, 8'hFF);
  endtask

  // Result side: random stalls, sampled at the rising edge.
  always @(negedge clk) m_tready <= no_gaps || ($urandom_range(99) >= 22);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  initial begin
    logic [7:0] glob_q [$];
    logic [7:0] text_q [$];
    int glen;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern: only the empty subject matches
    try_subject("");
    send_word(CMD_SUBJECT, 8'h00);
    send_word(CMD_END, 8'hFF);
    // any byte, caret negation with range, unclosed class
    load_glob("?[^a-c");
    try_subject("xd");
    send_word(CMD_SUBJECT, 8'hFF);
    send_word(CMD_END, 8'h00);
    // close right after the negation mark gives an empty class, then star and literal dash
    load_glob("[!]*-");
    try_subject("q-");

    while (words_sent < WORD_TARGET) begin
      no_gaps = (words_sent >= 250 && words_sent < 400);
      if ($urandom_range(99) < 8) begin
        send_word(gwm_cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        glen = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(7);
        glob_q.delete();
        // now and then append onto the old pattern instead of starting over
        if ($urandom_range(9) != 0) send_word(CMD_CLEAR, 8'($urandom_range(255)));
        repeat (glen) begin
          glob_q.push_back(($urandom_range(99) < 85) ? GLOB_SET[$urandom_range(9)]
                                                     : 8'($urandom_range(255)));
          send_word(CMD_APPEND, glob_q[$]);
        end
        repeat ($urandom_range(4, 1)) begin
          text_q.delete();
          if ($urandom_range(1) == 0) begin
            // subject shaped after the pattern, so matches are common
            foreach (glob_q[i]) begin
              case (glob_q[i]) inside
                CH_STAR:  repeat ($urandom_range(2)) text_q.push_back(pick_text_byte());
                CH_ANY:   text_q.push_back(8'($urandom_range(255)));
                CH_OPEN, CH_CLOSE, CH_BANG, CH_CARET: text_q.push_back(pick_text_byte());
                default:  text_q.push_back(glob_q[i]);
              endcase
            end
          end else begin
            repeat ($urandom_range(8)) text_q.push_back(pick_text_byte());
          end
          foreach (text_q[i]) send_word(CMD_SUBJECT, text_q[i]);
          send_word(CMD_END, 8'($urandom_range(255)));
        end
      end
    end
    no_gaps = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[glob_wildcard_matcher.f]
rtl/gwm_pkg.sv
rtl/gwm_walk.sv
rtl/glob_wildcard_matcher.sv
rtl/gwm_checker.sv
sim/glob_wildcard_matcher_test.sv
